### sv/kpa_pkg.sv
// Shared constants, codes and item types for the keyframe automation block.
package kpa_pkg;
    localparam int NUM_BANKS  = 4;
    localparam int MAX_FRAMES = 64;
    localparam int NPAR       = 6;
    localparam int BANK_W     = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
    localparam int FIDX_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
    localparam int ADDR_W     = BANK_W + FIDX_W;
    localparam int DEPTH      = NUM_BANKS * MAX_FRAMES;
    localparam logic [31:0] IVL_NUM = 32'd60000;

    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_RECORD  = 2'd1;
    localparam logic [1:0] OP_CAPTURE = 2'd2;
    localparam logic [1:0] OP_PLAY    = 2'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_DUP   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  bank;
        logic [31:0] elapsed_ms;
        logic [15:0] bpm_in;
        logic [15:0] ontime_in;
        logic [7:0]  drunk_in;
        logic [7:0]  prob_in;
        logic [7:0]  steps_in;
        logic [7:0]  scrub_in;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic        bank_has_data;
        logic [15:0] play_pos_ms;
        logic [15:0] bpm_out;
        logic [15:0] ontime_out;
        logic [7:0]  drunk_out;
        logic [7:0]  prob_out;
        logic [7:0]  steps_out;
        logic [7:0]  scrub_out;
        logic [13:0] interval_ms;
    } t_res;

    typedef struct packed {
        logic [15:0] bpm;
        logic [15:0] ontime;
        logic [7:0]  drunk;
        logic [7:0]  prob;
        logic [7:0]  steps;
        logic [7:0]  scrub;
    } t_vals;

    typedef struct packed {
        logic [15:0] stamp;
        t_vals       vals;
    } t_frame;

    typedef struct packed {
        logic in_range;
        t_req req;
    } t_cmd;

    function automatic logic [15:0] par_of(input t_vals v, input logic [2:0] p);
        logic [15:0] r;
        case (p)
            3'd0:    r = v.bpm;
            3'd1:    r = v.ontime;
            3'd2:    r = {8'd0, v.drunk};
            3'd3:    r = {8'd0, v.prob};
            3'd4:    r = {8'd0, v.steps};
            default: r = {8'd0, v.scrub};
        endcase
        return r;
    endfunction

    function automatic logic [15:0] par_mask(input logic [2:0] p, input logic [15:0] x);
        return (p < 3'd2) ? x : {8'd0, x[7:0]};
    endfunction
endpackage

### sv/kpa_div.sv
// Radix-2 restoring divider, 32 by 32 bits, one quotient bit per cycle.
module kpa_div import kpa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quo,
    output logic [31:0] o_rem
);
    logic        r_busy, r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_q, r_r, r_d;
    logic [32:0] sh, diff;

    assign sh   = {r_r, r_q[31]};
    assign diff = sh - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend;
            r_r <= '0;
            r_d <= i_divisor;
        end else if (r_busy) begin
            r_q <= {r_q[30:0], ~diff[32]};
            r_r <= diff[32] ? sh[31:0] : diff[31:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
    assign o_rem  = r_r;
endmodule

### sv/kpa_front.sv
// Front end: takes requests, flags the bank range and queues them two deep.
module kpa_front import kpa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    output logic o_busy,
    input  t_req i_req,
    output logic o_cmd_valid,
    output t_cmd o_cmd,
    input  logic i_cmd_pop
);
    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_busy      = (r_cnt == 2'd2);
    assign push        = i_start && !o_busy;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp].req      <= i_req;
            r_q[r_wp].in_range <= ({1'b0, i_req.bank} < 5'(NUM_BANKS));
        end
    end
endmodule

### sv/kpa_back.sv
// Back end: bank state, frame memory, scan and interpolation sequencer.
module kpa_back import kpa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_valid,
    input  t_cmd i_cmd,
    output logic o_cmd_pop,
    output logic o_strobe,
    output t_res o_res
);
    localparam logic [3:0] S_IDLE = 4'd0, S_EXEC = 4'd1, S_POSW = 4'd2, S_RD = 4'd3,
                           S_CMP  = 4'd4, S_PICK = 4'd5, S_MUL = 4'd6, S_DIVW = 4'd7,
                           S_IVL  = 4'd8, S_IVLW = 4'd9, S_OUT = 4'd10;

    logic [3:0]        r_state;
    t_cmd              r_cmd;
    logic [CNT_W-1:0]  r_count [NUM_BANKS];
    t_vals             r_svals [NUM_BANKS];
    logic [15:0]       r_dur   [NUM_BANKS];
    logic [NUM_BANKS-1:0] r_has;
    logic [15:0]       r_last;
    logic              r_last_v;
    t_frame            r_mem [DEPTH];
    t_frame            r_rdata;
    logic [1:0]        r_status;
    logic [15:0]       r_pos;
    logic [15:0]       r_res [NPAR];
    logic [13:0]       r_ivl;
    logic [CNT_W-1:0]  r_idx;
    logic              r_lo_v, r_hi_v;
    logic [FIDX_W-1:0] r_lo_i, r_hi_i;
    t_frame            r_lo_f, r_hi_f;
    logic [31:0]       r_num, r_den;
    logic              r_up;
    logic [2:0]        r_p;
    logic              r_go;
    logic [31:0]       r_dvd, r_dvs;
    logic              r_strobe;
    t_res              r_out;

    logic              dv_done;
    logic [31:0]       dv_quo, dv_rem;
    logic [BANK_W-1:0] b;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic              wr_en;
    logic [15:0]       pa, pb, q16;
    logic [CNT_W-1:0]  cnt_b;

    assign b       = r_cmd.req.bank[BANK_W-1:0];
    assign cnt_b   = r_count[b];
    assign rd_addr = {b, r_idx[FIDX_W-1:0]};
    assign wr_addr = {b, cnt_b[FIDX_W-1:0]};
    assign wr_en   = (r_state == S_EXEC) && r_cmd.in_range && (r_cmd.req.opcode == OP_RECORD)
                     && !(r_last_v && r_last == r_cmd.req.elapsed_ms[15:0])
                     && (cnt_b != CNT_W'(MAX_FRAMES));
    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;
    assign pa  = par_of(r_lo_f.vals, r_p);
    assign pb  = par_of(r_hi_f.vals, r_p);
    assign q16 = dv_quo[15:0];

    kpa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_go),
        .i_dividend (r_dvd),
        .i_divisor  (r_dvs),
        .o_done     (dv_done),
        .o_quo      (dv_quo),
        .o_rem      (dv_rem)
    );

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= {r_cmd.req.elapsed_ms[15:0], r_cmd.req.bpm_in,
                r_cmd.req.ontime_in, r_cmd.req.drunk_in, r_cmd.req.prob_in,
                r_cmd.req.steps_in, r_cmd.req.scrub_in};
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_has    <= '0;
            r_last   <= '0;
            r_last_v <= 1'b0;
            r_go     <= 1'b0;
            r_strobe <= 1'b0;
            for (int i = 0; i < NUM_BANKS; i++) begin
                r_count[i] <= '0;
                r_svals[i] <= '0;
                r_dur[i]   <= '0;
            end
        end else begin
            r_go     <= 1'b0;
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd   <= i_cmd;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_status <= ST_DONE;
                    r_pos    <= '0;
                    r_ivl    <= '0;
                    for (int i = 0; i < NPAR; i++) r_res[i] <= '0;
                    r_idx  <= '0;
                    r_lo_v <= 1'b0;
                    r_hi_v <= 1'b0;
                    r_state <= S_OUT;
                    if (!r_cmd.in_range) begin
                        r_status <= ST_RANGE;
                    end else begin
                        unique case (r_cmd.req.opcode)
                            OP_CLEAR: begin
                                r_count[b] <= '0;
                                r_last_v   <= 1'b0;
                            end
                            OP_RECORD: begin
                                if (r_last_v && r_last == r_cmd.req.elapsed_ms[15:0]) begin
                                    r_status <= ST_DUP;
                                end else begin
                                    r_last   <= r_cmd.req.elapsed_ms[15:0];
                                    r_last_v <= 1'b1;
                                    if (cnt_b == CNT_W'(MAX_FRAMES)) r_status <= ST_FULL;
                                    else r_count[b] <= cnt_b + 1'b1;
                                end
                            end
                            OP_CAPTURE: begin
                                r_svals[b] <= {r_cmd.req.bpm_in, r_cmd.req.ontime_in,
                                    r_cmd.req.drunk_in, r_cmd.req.prob_in,
                                    r_cmd.req.steps_in, r_cmd.req.scrub_in};
                                r_dur[b] <= r_cmd.req.elapsed_ms[15:0];
                                r_has[b] <= 1'b1;
                            end
                            default: begin
                                if (r_dur[b] != 16'd0) begin
                                    r_dvd   <= r_cmd.req.elapsed_ms;
                                    r_dvs   <= {16'd0, r_dur[b]};
                                    r_go    <= 1'b1;
                                    r_state <= S_POSW;
                                end else begin
                                    r_state <= (cnt_b == '0) ? S_PICK : S_RD;
                                end
                            end
                        endcase
                    end
                end
                S_POSW: begin
                    if (dv_done) begin
                        r_pos   <= dv_rem[15:0];
                        r_state <= (cnt_b == '0) ? S_PICK : S_RD;
                    end
                end
                S_RD: r_state <= S_CMP;
                S_CMP: begin
                    if (r_rdata.stamp <= r_pos) begin
                        r_lo_v <= 1'b1;
                        r_lo_i <= r_idx[FIDX_W-1:0];
                        r_lo_f <= r_rdata;
                    end
                    if (r_rdata.stamp >= r_pos && !r_hi_v) begin
                        r_hi_v <= 1'b1;
                        r_hi_i <= r_idx[FIDX_W-1:0];
                        r_hi_f <= r_rdata;
                    end
                    r_idx   <= r_idx + 1'b1;
                    r_state <= (r_idx + 1'b1 == cnt_b) ? S_PICK : S_RD;
                end
                S_PICK: begin
                    r_num   <= {16'd0, r_pos - r_lo_f.stamp};
                    r_den   <= {16'd0, r_hi_f.stamp} - {16'd0, r_lo_f.stamp};
                    r_p     <= '0;
                    r_state <= S_IVL;
                    if (!r_lo_v) begin
                        for (int i = 0; i < NPAR; i++) r_res[i] <= par_of(r_svals[b], 3'(i));
                    end else if (!r_hi_v || r_hi_i == r_lo_i
                                 || r_hi_f.stamp == r_lo_f.stamp) begin
                        for (int i = 0; i < NPAR; i++) r_res[i] <= par_of(r_lo_f.vals, 3'(i));
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_up    <= (pb >= pa);
                    r_state <= S_DIVW;
                    r_go    <= 1'b1;
                end
                S_DIVW: begin
                    if (dv_done) begin
                        r_res[r_p] <= par_mask(r_p, r_up ? pa + q16 : pa - q16);
                        r_p        <= r_p + 3'd1;
                        r_state    <= (r_p == 3'(NPAR - 1)) ? S_IVL : S_MUL;
                    end
                end
                S_IVL: begin
                    if (r_res[0] == 16'd0) begin
                        r_state <= S_OUT;
                    end else begin
                        r_dvd   <= IVL_NUM;
                        r_dvs   <= {14'd0, r_res[0], 2'b00};
                        r_go    <= 1'b1;
                        r_state <= S_IVLW;
                    end
                end
                S_IVLW: begin
                    if (dv_done) begin
                        r_ivl   <= dv_quo[13:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_strobe <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            // operands for the interpolation divide are launched from S_MUL
            if (r_state == S_MUL) begin
                r_dvd <= 32'((pb >= pa) ? pb - pa : pa - pb) * r_num;
                r_dvs <= r_den;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT) begin
            r_out.status        <= r_status;
            r_out.bank_has_data <= r_cmd.in_range && r_has[b];
            r_out.play_pos_ms   <= r_pos;
            r_out.bpm_out       <= r_res[0];
            r_out.ontime_out    <= r_res[1];
            r_out.drunk_out     <= r_res[2][7:0];
            r_out.prob_out      <= r_res[3][7:0];
            r_out.steps_out     <= r_res[4][7:0];
            r_out.scrub_out     <= r_res[5][7:0];
            r_out.interval_ms   <= r_ivl;
        end
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_out;
endmodule

### sv/keyframe_param_automation.sv
// Top level: keyframe recorder and interpolating player for six parameters.
// Clear, record and capture pass from execute straight to output; playback may add
// a modulo divide for the loop position, a read and compare per stored frame,
// a pick step, a divide per interpolated parameter and the interval divide.
// One item in flight in the back end; a two-deep queue takes requests ahead.
// Synchronous active-low reset clears bank counts, flags, start values and queue.
module keyframe_param_automation import kpa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_strobe,
    output t_res o_res
);
    logic cmd_valid, cmd_pop;
    t_cmd cmd;

    kpa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_req       (i_req),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    kpa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_strobe    (o_strobe),
        .o_res       (o_res)
    );
endmodule

### sv/kpa_checker.sv
// Port-level checks for the keyframe automation block, bound to the top level.
module kpa_checker import kpa_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_strobe,
    input t_res o_res
);
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe) else $error("back-to-back result strobes");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe && !busy) else $error("activity after reset");

    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_res.status == ST_RANGE |->
        o_res.play_pos_ms == 16'd0 && o_res.bpm_out == 16'd0 && !o_res.bank_has_data
        && o_res.interval_ms == 14'd0) else $error("out-of-range result not cleared");

    a_skip_ivl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_res.status == ST_DUP || o_res.status == ST_FULL) |->
        o_res.interval_ms == 14'd0 && o_res.play_pos_ms == 16'd0)
        else $error("skipped record carries playback data");
endmodule

bind keyframe_param_automation kpa_checker u_chk (.*);

### dv/tb_keyframe_param_automation.sv
// Testbench for the keyframe automation block: random and directed requests, scoreboard check.
`timescale 1ns / 1ps

module tb_keyframe_param_automation;
    import kpa_pkg::*;

    // Holds the player state and the queue of results still to come.
    class kpa_scoreboard;
        t_frame frames[NUM_BANKS][MAX_FRAMES];
        int     frame_cnt[NUM_BANKS];
        logic [15:0] last_stamp;
        bit     last_stamp_ok;
        t_vals  start_vals[NUM_BANKS];
        logic [15:0] loop_dur[NUM_BANKS];
        bit     captured[NUM_BANKS];
        t_res   pending[$];
        int     errors;

        function new();
            for (int b = 0; b < NUM_BANKS; b++) begin
                frame_cnt[b] = 0;
                start_vals[b] = '0;
                loop_dur[b] = '0;
                captured[b] = 0;
            end
            last_stamp = '0;
            last_stamp_ok = 0;
            errors = 0;
        endfunction

        function automatic t_vals vals_of(input t_req r);
            t_vals v;
            v.bpm = r.bpm_in;
            v.ontime = r.ontime_in;
            v.drunk = r.drunk_in;
            v.prob = r.prob_in;
            v.steps = r.steps_in;
            v.scrub = r.scrub_in;
            return v;
        endfunction

        function automatic int lerp(input int a, input int b, input longint num,
                                    input longint den);
            if (den == 0) return a;
            if (b >= a) return a + int'((longint'(b - a) * num) / den);
            return a - int'((longint'(a - b) * num) / den);
        endfunction

        function automatic t_vals blend(input t_vals a, input t_vals b, input longint num,
                                        input longint den);
            t_vals v;
            v.bpm = 16'(lerp(a.bpm, b.bpm, num, den));
            v.ontime = 16'(lerp(a.ontime, b.ontime, num, den));
            v.drunk = 8'(lerp(a.drunk, b.drunk, num, den));
            v.prob = 8'(lerp(a.prob, b.prob, num, den));
            v.steps = 8'(lerp(a.steps, b.steps, num, den));
            v.scrub = 8'(lerp(a.scrub, b.scrub, num, den));
            return v;
        endfunction

        function void note_request(input t_req r);
            t_res  e;
            t_vals v;
            int    b, lo, hi;
            logic [31:0] pos;
            e = '0;
            b = r.bank;
            if (b >= NUM_BANKS) begin
                e.status = ST_RANGE;
                pending.push_back(e);
                return;
            end
            case (r.opcode)
                OP_CLEAR: begin
                    frame_cnt[b] = 0;
                    last_stamp_ok = 0;
                end
                OP_RECORD: begin
                    if (last_stamp_ok && last_stamp == r.elapsed_ms[15:0]) begin
                        e.status = ST_DUP;
                    end else begin
                        last_stamp = r.elapsed_ms[15:0];
                        last_stamp_ok = 1;
                        if (frame_cnt[b] >= MAX_FRAMES) begin
                            e.status = ST_FULL;
                        end else begin
                            frames[b][frame_cnt[b]].stamp = r.elapsed_ms[15:0];
                            frames[b][frame_cnt[b]].vals = vals_of(r);
                            frame_cnt[b]++;
                        end
                    end
                end
                OP_CAPTURE: begin
                    start_vals[b] = vals_of(r);
                    loop_dur[b] = r.elapsed_ms[15:0];
                    captured[b] = 1;
                end
                default: begin
                    pos = (loop_dur[b] != 0) ? r.elapsed_ms % loop_dur[b] : 0;
                    lo = -1;
                    hi = -1;
                    for (int i = 0; i < frame_cnt[b]; i++) begin
                        if (frames[b][i].stamp <= pos) lo = i;
                        if (frames[b][i].stamp >= pos && hi < 0) hi = i;
                    end
                    if (lo < 0) v = start_vals[b];
                    else if (hi < 0 || hi == lo) v = frames[b][lo].vals;
                    else v = blend(frames[b][lo].vals, frames[b][hi].vals,
                                   pos - frames[b][lo].stamp,
                                   longint'(frames[b][hi].stamp) - frames[b][lo].stamp);
                    e.play_pos_ms = pos[15:0];
                    e.bpm_out = v.bpm;
                    e.ontime_out = v.ontime;
                    e.drunk_out = v.drunk;
                    e.prob_out = v.prob;
                    e.steps_out = v.steps;
                    e.scrub_out = v.scrub;
                    if (v.bpm != 0) e.interval_ms = 14'(60000 / (32'(v.bpm) * 4));
                end
            endcase
            e.bank_has_data = captured[b];
            pending.push_back(e);
        endfunction

        task automatic report(input string what, input logic [31:0] got,
                              input logic [31:0] want);
            $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
            errors++;
        endtask

        task automatic check_result(input t_res r);
            t_res e;
            if (pending.size() == 0) begin
                report("unexpected result", r.status, 0);
                return;
            end
            e = pending.pop_front();
            if (r.status !== e.status) report("status", r.status, e.status);
            if (r.bank_has_data !== e.bank_has_data)
                report("bank_has_data", r.bank_has_data, e.bank_has_data);
            if (r.play_pos_ms !== e.play_pos_ms)
                report("play_pos_ms", r.play_pos_ms, e.play_pos_ms);
            if (r.bpm_out !== e.bpm_out) report("bpm_out", r.bpm_out, e.bpm_out);
            if (r.ontime_out !== e.ontime_out)
                report("ontime_out", r.ontime_out, e.ontime_out);
            if (r.drunk_out !== e.drunk_out) report("drunk_out", r.drunk_out, e.drunk_out);
            if (r.prob_out !== e.prob_out) report("prob_out", r.prob_out, e.prob_out);
            if (r.steps_out !== e.steps_out) report("steps_out", r.steps_out, e.steps_out);
            if (r.scrub_out !== e.scrub_out) report("scrub_out", r.scrub_out, e.scrub_out);
            if (r.interval_ms !== e.interval_ms)
                report("interval_ms", r.interval_ms, e.interval_ms);
        endtask
    endclass

    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int NUM_ITEMS   = 1800;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_req i_req;
    logic o_strobe;
    t_res o_res;

    kpa_scoreboard sb;
    int  cycles;
    int  sent;
    bit  calm;
    logic [15:0] rec_time;

    keyframe_param_automation dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req(i_req), .o_strobe(o_strobe), .o_res(o_res)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_strobe) sb.check_result(o_res);
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_keyframe_param_automation: FAIL");
            $finish;
        end
    end

    // Drives one request; start stays up until the block takes it and is
    // only dropped by an idle gap or at the end of the run.
    task automatic send_request(input t_req r);
        if (!calm) begin
            while ($urandom_range(99) < 26) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_request(r);
        sent++;
    endtask

    function automatic t_req rand_request(input logic [1:0] op, input int bank);
        t_req r;
        r.opcode = op;
        r.bank = 4'(bank);
        r.elapsed_ms = $urandom();
        r.bpm_in = ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(300));
        r.ontime_in = 16'($urandom());
        r.drunk_in = 8'($urandom());
        r.prob_in = 8'($urandom());
        r.steps_in = 8'($urandom());
        r.scrub_in = 8'($urandom());
        return r;
    endfunction

    task automatic send_op(input logic [1:0] op, input int bank, input logic [31:0] el);
        t_req r;
        r = rand_request(op, bank);
        r.elapsed_ms = el;
        send_request(r);
    endtask

    // A well-formed take: clear, a run of rising stamps with some repeats, capture, then playbacks.
    task automatic record_take(input int bank);
        int n, dur;
        n = ($urandom_range(9) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 8);
        dur = $urandom_range(1, 3000);
        send_op(OP_CLEAR, bank, $urandom());
        rec_time = 16'($urandom_range(0, 20));
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(7) == 0) begin
                send_op(OP_RECORD, bank, {16'($urandom()), rec_time});
            end else begin
                rec_time = rec_time + 16'($urandom_range(1, 2 * dur / (n + 1) + 1));
                send_op(OP_RECORD, bank, {16'($urandom()), rec_time});
            end
        end
        send_op(OP_CAPTURE, bank, {16'($urandom()), 16'(dur)});
        repeat ($urandom_range(2, 8)) send_op(OP_PLAY, bank, $urandom());
    endtask

    initial begin
        t_req r;
        sb = new();
        cycles = 0;
        sent = 0;
        calm = 0;
        start = 1'b0;
        i_req = '0;
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty bank playback, out of range, extremes, duplicates, zero duration
        send_op(OP_PLAY, 0, 32'hFFFF_FFFF);
        send_op(OP_PLAY, 15, 0);
        send_op(OP_RECORD, NUM_BANKS, 5);
        r = '1;
        r.opcode = OP_CAPTURE;
        r.bank = 1;
        send_request(r);
        send_op(OP_PLAY, 1, 32'hFFFF_FFFF);
        send_op(OP_CAPTURE, 2, 0);
        send_op(OP_PLAY, 2, 1234);
        send_op(OP_RECORD, 0, 100);
        send_op(OP_RECORD, 0, 100);
        send_op(OP_RECORD, 0, 32'h0001_0064);
        send_op(OP_RECORD, 0, 300);
        send_op(OP_RECORD, 0, 300 + 65536);
        r = '0;
        r.opcode = OP_RECORD;
        r.elapsed_ms = 500;
        send_request(r);
        r.elapsed_ms = 800;
        r.bpm_in = 16'hFFFF;
        r.ontime_in = 16'hFFFF;
        r.drunk_in = 8'hFF;
        send_request(r);
        send_op(OP_CAPTURE, 0, 1000);
        send_op(OP_PLAY, 0, 50);
        send_op(OP_PLAY, 0, 100);
        send_op(OP_PLAY, 0, 200);
        send_op(OP_PLAY, 0, 650);
        send_op(OP_PLAY, 0, 900);
        send_op(OP_CLEAR, 0, 0);
        send_op(OP_PLAY, 0, 3100);

        // random: mostly well-formed takes, some noise
        while (sent < NUM_ITEMS) begin
            calm = ($urandom_range(9) == 0);
            if ($urandom_range(3) == 0) begin
                repeat ($urandom_range(1, 6))
                    send_request(rand_request(2'($urandom()), $urandom_range(0, 15)));
            end else begin
                record_take($urandom_range(0, NUM_BANKS - 1));
            end
            if (sb.errors > 50) break;
        end
        start <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_keyframe_param_automation: PASS");
        else
            $display("tb_keyframe_param_automation: FAIL");
        $finish;
    end
endmodule

### keyframe_param_automation.f
sv/kpa_pkg.sv
sv/kpa_div.sv
sv/kpa_front.sv
sv/kpa_back.sv
sv/keyframe_param_automation.sv
sv/kpa_checker.sv
dv/tb_keyframe_param_automation.sv
